// File: hw/rtl/ecg_pkg.sv
// Shared widths, constants, handshake types and the CORDIC step-angle table
// for the earth-fixed to geodetic converter. No dependencies.
package ecg_pkg;

  localparam int CW      = 56;  // CORDIC x/y datapath
  localparam int AW      = 36;  // angles at 2^-32 rad
  localparam int MUL_A_W = 56;
  localparam int MUL_B_W = 34;
  localparam int MUL_P_W = 90;
  localparam int DIV_N_W = 72;
  localparam int DIV_D_W = 32;
  localparam int DIV_Q_W = 57;
  localparam int SQ_V_W  = 62;
  localparam int SQ_R_W  = 31;

  localparam logic signed [AW-1:0] HALFPI32  = 36'sd6746518852;
  localparam logic signed [AW-1:0] DEG32     = 36'sd74961321;
  localparam logic signed [AW-1:0] PI29      = 36'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI29  = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALFPI29  = 36'sd843314857;
  localparam logic [31:0]          INVK32    = 32'd2608131496;
  localparam logic signed [CW-1:0] XCOS0     = 56'sd652032874;
  localparam logic [DIV_Q_W-1:0]   CMAX      = 57'd1 << 50;
  localparam logic [DIV_Q_W-1:0]   QMAX      = 57'd1 << 56;

  typedef enum logic {CORDIC_VEC, CORDIC_ROT} cordic_mode_t;
  typedef enum logic [1:0] {SH28, SH30, SH32} mul_shift_t;
  typedef enum logic {LIM_C, LIM_Q} div_lim_t;

  typedef struct packed {
    logic         start;
    cordic_mode_t mode;
  } cordic_ctl_t;

  typedef struct packed {
    logic       start;
    mul_shift_t shift;
  } mul_ctl_t;

  typedef struct packed {
    logic     start;
    div_lim_t lim;
  } div_ctl_t;

  function automatic logic [AW-1:0] atan_step(input logic [4:0] i);
    logic [AW-1:0] v;
    unique case (i)
      5'd0:    v = 36'd3373259426;
      5'd1:    v = 36'd1991351318;
      5'd2:    v = 36'd1052175346;
      5'd3:    v = 36'd534100635;
      5'd4:    v = 36'd268086748;
      5'd5:    v = 36'd134174063;
      5'd6:    v = 36'd67103403;
      5'd7:    v = 36'd33553749;
      5'd8:    v = 36'd16777131;
      5'd9:    v = 36'd8388597;
      5'd10:   v = 36'd4194303;
      default: v = AW'(64'd1 << (6'd32 - {1'b0, i}));
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/ecg_in_if.sv
// Input channel: valid/ready handshake carrying one earth-fixed position.
// No dependencies.
interface ecg_in_if;
  logic              valid;
  logic              ready;
  logic signed [32:0] pos_x;
  logic signed [32:0] pos_y;
  logic signed [32:0] pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// File: hw/rtl/ecg_out_if.sv
// Output channel: valid/ready handshake carrying one geodetic result.
// No dependencies.
interface ecg_out_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] latitude;
  logic signed [31:0] longitude;
  logic signed [32:0] altitude;
  logic               invalid;
  modport source (output valid, latitude, longitude, altitude, invalid, input ready);
  modport sink (input valid, latitude, longitude, altitude, invalid, output ready);
endinterface

// File: hw/rtl/ecg_cordic.sv
// Shared 32-step CORDIC engine, vectoring or rotation, one step per cycle.
// Depends on ecg_pkg.
module ecg_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  ecg_pkg::cordic_ctl_t          ctl,
  input  logic signed [ecg_pkg::CW-1:0] x_in,
  input  logic signed [ecg_pkg::CW-1:0] y_in,
  input  logic signed [ecg_pkg::AW-1:0] z_in,
  output logic signed [ecg_pkg::CW-1:0] x_out,
  output logic signed [ecg_pkg::CW-1:0] y_out,
  output logic signed [ecg_pkg::AW-1:0] z_out,
  output logic                          done
);
  import ecg_pkg::*;

  logic                 busy;
  logic [4:0]           step;
  cordic_mode_t         mode;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic                 ccw;
  logic [AW-1:0]        ang;

  assign dx  = y_out >>> step;
  assign dy  = x_out >>> step;
  assign ccw = (mode == CORDIC_ROT) ? !z_out[AW-1] : y_out[CW-1];
  assign ang = atan_step(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      mode <= CORDIC_VEC;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        step <= '0;
        mode <= ctl.mode;
        if (ctl.mode == CORDIC_VEC && x_in[CW-1]) begin
          if (!y_in[CW-1]) begin
            x_out <= y_in;
            y_out <= -x_in;
            z_out <= HALFPI32;
          end else begin
            x_out <= -y_in;
            y_out <= x_in;
            z_out <= -HALFPI32;
          end
        end else begin
          x_out <= x_in;
          y_out <= y_in;
          z_out <= z_in;
        end
      end else if (busy) begin
        if (ccw) begin
          x_out <= x_out - dx;
          y_out <= y_out + dy;
          z_out <= z_out - $signed(ang);
        end else begin
          x_out <= x_out + dx;
          y_out <= y_out - dy;
          z_out <= z_out + $signed(ang);
        end
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/ecg_mul.sv
// Multi-cycle multiplier: four 32x32 partial products accumulated, then a
// right shift by 28, 30 or 32. Depends on ecg_pkg.
module ecg_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  ecg_pkg::mul_ctl_t           ctl,
  input  logic [ecg_pkg::MUL_A_W-1:0] a,
  input  logic [ecg_pkg::MUL_B_W-1:0] b,
  output logic [ecg_pkg::MUL_A_W-1:0] res,
  output logic                        done
);
  import ecg_pkg::*;

  logic               busy;
  logic [1:0]         step;
  mul_shift_t         shift;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_P_W-1:0] acc;
  logic [31:0]        ma;
  logic [31:0]        mb;
  logic [63:0]        pp;
  logic [MUL_P_W-1:0] pp_sh;

  assign ma = step[0] ? 32'(a_r[MUL_A_W-1:32]) : a_r[31:0];
  assign mb = step[1] ? 32'(b_r[MUL_B_W-1:32]) : b_r[31:0];
  assign pp = ma * mb;

  always_comb begin
    unique case (step)
      2'd0:    pp_sh = MUL_P_W'(pp);
      2'd1,
      2'd2:    pp_sh = MUL_P_W'(pp) << 32;
      default: pp_sh = MUL_P_W'(pp) << 64;
    endcase
  end

  always_comb begin
    unique case (shift)
      SH28:    res = acc[28 +: MUL_A_W];
      SH30:    res = acc[30 +: MUL_A_W];
      default: res = acc[32 +: MUL_A_W];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      step  <= '0;
      shift <= SH32;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        step  <= '0;
        shift <= ctl.shift;
        a_r   <= a;
        b_r   <= b;
        acc   <= '0;
      end else if (busy) begin
        acc  <= acc + pp_sh;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/ecg_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle, with the
// quotient saturated at a selectable limit. Depends on ecg_pkg.
module ecg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  ecg_pkg::div_ctl_t           ctl,
  input  logic [ecg_pkg::DIV_N_W-1:0] num,
  input  logic [ecg_pkg::DIV_D_W-1:0] den,
  output logic [ecg_pkg::DIV_Q_W-1:0] quo,
  output logic                        done
);
  import ecg_pkg::*;

  logic               busy;
  logic [6:0]         cnt;
  div_lim_t           lim;
  logic [DIV_N_W-1:0] n_r;
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_N_W-1:0] q_r;
  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W:0]   diff;
  logic               ge;
  logic [DIV_Q_W-1:0] maxq;

  assign rem_sh = {rem, n_r[DIV_N_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign maxq   = (lim == LIM_C) ? CMAX : QMAX;
  assign quo    = (q_r > DIV_N_W'(maxq)) ? maxq : q_r[DIV_Q_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      lim  <= LIM_C;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        lim   <= ctl.lim;
        n_r   <= num;
        den_r <= den;
        rem   <= '0;
        q_r   <= '0;
      end else if (busy) begin
        rem <= ge ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        q_r <= {q_r[DIV_N_W-2:0], ge};
        n_r <= n_r << 1;
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/ecg_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on ecg_pkg.
module ecg_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ecg_pkg::SQ_V_W-1:0] v,
  output logic [ecg_pkg::SQ_R_W-1:0] root,
  output logic                       done
);
  import ecg_pkg::*;

  logic              busy;
  logic [4:0]        cnt;
  logic [SQ_V_W-1:0] v_r;
  logic [SQ_R_W+1:0] rem;
  logic [SQ_R_W+3:0] rem_sh;
  logic [SQ_R_W+3:0] trial;
  logic [SQ_R_W+3:0] diff;
  logic              ge;

  assign rem_sh = {rem, v_r[SQ_V_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        v_r  <= v;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[SQ_R_W+1:0] : rem_sh[SQ_R_W+1:0];
        root <= {root[SQ_R_W-2:0], ge};
        v_r  <= v_r << 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'(SQ_R_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/ecef_to_geodetic_core.sv
// Earth-fixed (x, y, z) to geodetic latitude, longitude and altitude.
// One item at a time: ready is high only while the sequencer is idle. An item
// runs 1 to iteration_limit latitude refinement passes (a limit of 0 counts
// as 1), using the shared 32-step CORDIC engine, the bit-serial divider and
// the square root, all driven in turn by the sequencer below. A finished
// result waits in the output register while the next item is accepted.
module ecef_to_geodetic_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  ecg_in_if.sink      in_item,
  ecg_out_if.source   out_item
);
  import ecg_pkg::*;

  typedef enum logic [1:0] {
    REG_EQ_RADIUS, REG_ECC_SQ, REG_ANG_TOL, REG_ITER_LIM
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_LON_W, S_RHO_W, S_LAT0_W, S_ROT_W, S_SQ_W, S_ES_W,
    S_SQRT_W, S_DIV_W, S_CE_W, S_TS_W, S_VEC_W, S_CLAMP, S_FIN_W,
    S_ALT_MUL_W, S_ALT_DIV_W, S_ALT, S_OUT
  } state_t;

  state_t state;

  logic [31:0] eq_radius;
  logic [31:0] ecc;
  logic [9:0]  tol;
  logic [3:0]  iter_lim;

  logic signed [32:0]   px;
  logic signed [32:0]   py;
  logic signed [32:0]   pz;
  logic signed [31:0]   lon;
  logic [41:0]          rho;
  logic signed [AW-1:0] lat;
  logic signed [AW-1:0] old;
  logic signed [CW-1:0] si;
  logic signed [CW-1:0] co;
  logic [32:0]          s2;
  logic [32:0]          dd;
  logic [SQ_R_W-1:0]    root;
  logic [50:0]          c;
  logic [50:0]          t;
  logic signed [CW-1:0] num;
  logic [3:0]           k;
  logic                 use_cos;
  logic [DIV_Q_W-1:0]   q;
  logic [50:0]          alt_sub;

  logic signed [30:0] res_lat;
  logic signed [31:0] res_lon;
  logic signed [32:0] res_alt;
  logic               res_inv;
  logic               out_valid;
  logic signed [30:0] out_lat;
  logic signed [31:0] out_lon;
  logic signed [32:0] out_alt;
  logic               out_inv;

  logic cor_start;
  logic mul_start;
  logic div_start;
  logic sq_start;

  cordic_ctl_t          cor_ctl;
  logic signed [CW-1:0] cor_xi;
  logic signed [CW-1:0] cor_yi;
  logic signed [AW-1:0] cor_zi;
  logic signed [CW-1:0] cor_x;
  logic signed [CW-1:0] cor_y;
  logic signed [AW-1:0] cor_z;
  logic                 cor_done;

  mul_ctl_t           mul_ctl;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_A_W-1:0] mul_res;
  logic               mul_done;

  div_ctl_t           div_ctl;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic [DIV_Q_W-1:0] div_q;
  logic               div_done;

  logic [SQ_R_W-1:0] sq_root;
  logic              sq_done;

  logic signed [CW-1:0] x24;
  logic signed [CW-1:0] y24;
  logic signed [CW-1:0] z24;
  logic [CW-1:0]        z_mag;
  logic [CW-1:0]        si_mag;
  logic [32:0]          one_m_e2;
  logic signed [AW-1:0] lon_rnd;
  logic signed [AW-1:0] lon_wrap;
  logic signed [AW:0]   diff;
  logic [AW:0]          diff_mag;
  logic                 conv;
  logic [3:0]           lim;
  logic [3:0]           k_next;
  logic signed [AW-1:0] lat_cl;
  logic [AW-1:0]        lat_mag;
  logic                 cos_form;
  logic                 neg_q;
  logic signed [58:0]   qs;
  logic signed [58:0]   alt;
  logic signed [58:0]   alt_rnd;
  logic signed [AW-1:0] lat_rnd;

  assign x24      = {{(CW-41){px[32]}}, px, 8'b0};
  assign y24      = {{(CW-41){py[32]}}, py, 8'b0};
  assign z24      = {{(CW-41){pz[32]}}, pz, 8'b0};
  assign z_mag    = z24[CW-1] ? -z24 : z24;
  assign si_mag   = si[CW-1] ? -si : si;
  assign one_m_e2 = 33'h1_0000_0000 - {1'b0, ecc};

  assign lon_rnd  = (cor_z + 36'sd4) >>> 3;
  assign lon_wrap = (lon_rnd >= PI29) ? lon_rnd - TWO_PI29 :
                    (lon_rnd <= -PI29) ? lon_rnd + TWO_PI29 : lon_rnd;

  assign diff     = {cor_z[AW-1], cor_z} - {old[AW-1], old};
  assign diff_mag = diff[AW] ? -diff : diff;
  assign conv     = diff_mag < {24'b0, tol, 3'b0};
  assign lim      = (iter_lim == 4'd0) ? 4'd1 : iter_lim;
  assign k_next   = k + 4'd1;

  assign lat_cl   = (lat > HALFPI32) ? HALFPI32 : (lat < -HALFPI32) ? -HALFPI32 : lat;
  assign lat_mag  = lat[AW-1] ? -lat : lat;
  assign cos_form = (HALFPI32 - $signed(lat_mag)) > DEG32;

  assign neg_q   = !use_cos && ((si != '0 && (pz[32] != si[CW-1])) ||
                                (si == '0 && pz[32]));
  assign qs      = neg_q ? -$signed({2'b0, q}) : $signed({2'b0, q});
  assign alt     = qs - $signed({8'b0, alt_sub});
  assign alt_rnd = (alt + 59'sd128) >>> 8;
  assign lat_rnd = (lat + 36'sd4) >>> 3;

  always_comb begin
    cor_ctl.start = cor_start;
    cor_ctl.mode  = CORDIC_VEC;
    cor_xi        = x24;
    cor_yi        = y24;
    cor_zi        = '0;
    unique case (state)
      S_LAT0_W: begin
        cor_xi = {{(CW-42){1'b0}}, rho};
        cor_yi = z24;
      end
      S_VEC_W: begin
        cor_xi = {{(CW-42){1'b0}}, rho};
        cor_yi = num;
      end
      S_ROT_W, S_FIN_W: begin
        cor_ctl.mode = CORDIC_ROT;
        cor_xi       = XCOS0;
        cor_yi       = '0;
        cor_zi       = lat;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_ctl.start = mul_start;
    mul_ctl.shift = SH32;
    mul_a         = $unsigned(cor_x);
    mul_b         = {2'b0, INVK32};
    unique case (state)
      S_SQ_W: begin
        mul_ctl.shift = SH28;
        mul_a         = si_mag;
        mul_b         = si_mag[MUL_B_W-1:0];
      end
      S_ES_W: begin
        mul_a = {24'b0, ecc};
        mul_b = {1'b0, s2};
      end
      S_CE_W: begin
        mul_a = {5'b0, c};
        mul_b = {2'b0, ecc};
      end
      S_TS_W: begin
        mul_ctl.shift = SH30;
        mul_a         = {5'b0, t};
        mul_b         = si_mag[MUL_B_W-1:0];
      end
      S_ALT_MUL_W: begin
        mul_a = {5'b0, c};
        mul_b = {1'b0, one_m_e2};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_ctl.start = div_start;
    div_ctl.lim   = LIM_Q;
    div_n         = {2'b0, eq_radius, 38'b0};
    div_d         = {1'b0, root};
    priority if (state == S_DIV_W) begin
      div_ctl.lim = LIM_C;
    end else if (use_cos) begin
      div_n = {rho, 30'b0};
      div_d = co[DIV_D_W-1:0];
    end else begin
      div_n = {z_mag[41:0], 30'b0};
      div_d = si_mag[DIV_D_W-1:0];
    end
  end

  ecg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cor_ctl),
    .x_in  (cor_xi),
    .y_in  (cor_yi),
    .z_in  (cor_zi),
    .x_out (cor_x),
    .y_out (cor_y),
    .z_out (cor_z),
    .done  (cor_done)
  );

  ecg_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .res  (mul_res),
    .done (mul_done)
  );

  ecg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .num  (div_n),
    .den  (div_d),
    .quo  (div_q),
    .done (div_done)
  );

  ecg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .v     ({1'b0, dd, 28'b0}),
    .root  (sq_root),
    .done  (sq_done)
  );

  assign in_item.ready      = (state == S_IDLE);
  assign out_item.valid     = out_valid;
  assign out_item.latitude  = out_lat;
  assign out_item.longitude = out_lon;
  assign out_item.altitude  = out_alt;
  assign out_item.invalid   = out_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cor_start <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      eq_radius <= 32'd417997586;
      ecc       <= 32'd28752165;
      tol       <= 10'd5;
      iter_lim  <= 4'd9;
    end else begin
      cor_start <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;

      if (wr_en) begin
        unique case (reg_index_t'(wr_index))
          REG_EQ_RADIUS: eq_radius <= wr_data;
          REG_ECC_SQ:    ecc       <= wr_data;
          REG_ANG_TOL:   tol       <= wr_data[9:0];
          REG_ITER_LIM:  iter_lim  <= wr_data[3:0];
        endcase
      end

      if (out_valid && out_item.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_item.valid) begin
            px    <= in_item.pos_x;
            py    <= in_item.pos_y;
            pz    <= in_item.pos_z;
            state <= S_START;
          end
        end
        S_START: begin
          priority if (px == '0 && py == '0 && pz == '0) begin
            res_lat <= '0;
            res_lon <= '0;
            res_alt <= '0;
            res_inv <= 1'b1;
            state   <= S_OUT;
          end else if (px == '0 && py == '0) begin
            lon       <= pz[32] ? -HALFPI29[31:0] : HALFPI29[31:0];
            rho       <= '0;
            cor_start <= 1'b1;
            state     <= S_LAT0_W;
          end else begin
            cor_start <= 1'b1;
            state     <= S_LON_W;
          end
        end
        S_LON_W: begin
          if (cor_done) begin
            lon       <= lon_wrap[31:0];
            mul_start <= 1'b1;
            state     <= S_RHO_W;
          end
        end
        S_RHO_W: begin
          if (mul_done) begin
            rho       <= mul_res[41:0];
            cor_start <= 1'b1;
            state     <= S_LAT0_W;
          end
        end
        S_LAT0_W: begin
          if (cor_done) begin
            lat       <= cor_z;
            k         <= '0;
            cor_start <= 1'b1;
            state     <= S_ROT_W;
          end
        end
        S_ROT_W: begin
          if (cor_done) begin
            si        <= cor_y;
            old       <= lat;
            mul_start <= 1'b1;
            state     <= S_SQ_W;
          end
        end
        S_SQ_W: begin
          if (mul_done) begin
            s2        <= (mul_res > 56'h1_0000_0000) ? 33'h1_0000_0000 : mul_res[32:0];
            mul_start <= 1'b1;
            state     <= S_ES_W;
          end
        end
        S_ES_W: begin
          if (mul_done) begin
            dd       <= 33'h1_0000_0000 - mul_res[32:0];
            sq_start <= 1'b1;
            state    <= S_SQRT_W;
          end
        end
        S_SQRT_W: begin
          if (sq_done) begin
            root      <= sq_root;
            div_start <= 1'b1;
            state     <= S_DIV_W;
          end
        end
        S_DIV_W: begin
          if (div_done) begin
            c         <= div_q[50:0];
            mul_start <= 1'b1;
            state     <= S_CE_W;
          end
        end
        S_CE_W: begin
          if (mul_done) begin
            t         <= mul_res[50:0];
            mul_start <= 1'b1;
            state     <= S_TS_W;
          end
        end
        S_TS_W: begin
          if (mul_done) begin
            num       <= si[CW-1] ? z24 - $signed(mul_res) : z24 + $signed(mul_res);
            cor_start <= 1'b1;
            state     <= S_VEC_W;
          end
        end
        S_VEC_W: begin
          if (cor_done) begin
            lat <= cor_z;
            k   <= k_next;
            if (conv || k_next >= lim) begin
              state <= S_CLAMP;
            end else begin
              cor_start <= 1'b1;
              state     <= S_ROT_W;
            end
          end
        end
        S_CLAMP: begin
          lat       <= lat_cl;
          cor_start <= 1'b1;
          state     <= S_FIN_W;
        end
        S_FIN_W: begin
          if (cor_done) begin
            co      <= cor_x;
            si      <= cor_y;
            use_cos <= cos_form;
            if (cos_form) begin
              alt_sub <= c;
              if (cor_x > 0) begin
                div_start <= 1'b1;
                state     <= S_ALT_DIV_W;
              end else begin
                q     <= QMAX;
                state <= S_ALT;
              end
            end else begin
              mul_start <= 1'b1;
              state     <= S_ALT_MUL_W;
            end
          end
        end
        S_ALT_MUL_W: begin
          if (mul_done) begin
            alt_sub   <= mul_res[50:0];
            div_start <= 1'b1;
            state     <= S_ALT_DIV_W;
          end
        end
        S_ALT_DIV_W: begin
          if (div_done) begin
            q     <= div_q;
            state <= S_ALT;
          end
        end
        S_ALT: begin
          priority if (alt_rnd > 59'sd4294967295) res_alt <= 33'sh0_FFFF_FFFF;
          else if (alt_rnd < -59'sd4294967296) res_alt <= 33'sh1_0000_0000;
          else res_alt <= alt_rnd[32:0];
          priority if (lat_rnd > HALFPI29) res_lat <= HALFPI29[30:0];
          else if (lat_rnd < -HALFPI29) res_lat <= -HALFPI29[30:0];
          else res_lat <= lat_rnd[30:0];
          res_lon <= lon;
          res_inv <= 1'b0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_item.ready) begin
            out_valid <= 1'b1;
            out_lat   <= res_lat;
            out_lon   <= res_lon;
            out_alt   <= res_alt;
            out_inv   <= res_inv;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("ready high right after an accepted item");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_item.valid && out_item.invalid) |->
      (out_item.latitude == '0 && out_item.longitude == '0 && out_item.altitude == '0))
    else $error("invalid result with nonzero fields");

  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |->
      (out_item.latitude <= 31'sd843314857 && out_item.latitude >= -31'sd843314857))
    else $error("latitude out of range");

  a_cordic_done_state: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == S_LON_W || state == S_LAT0_W || state == S_ROT_W ||
                  state == S_VEC_W || state == S_FIN_W))
    else $error("CORDIC finished outside a wait state");
`endif

endmodule

// File: tb/ecef_to_geodetic_core_tb.sv
// Testbench for ecef_to_geodetic_core: drives earth-fixed positions, predicts
// latitude, longitude and altitude with a bit-exact CORDIC model and checks them.
// Depends on ecg_pkg, ecg_in_if, ecg_out_if and the core.
module ecef_to_geodetic_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecg_pkg::*;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } position_t;

  typedef struct {
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic signed [32:0] altitude;
    logic               invalid;
  } geodetic_t;

  localparam longint unsigned SAT62 = 64'd1 << 62;
  localparam longint unsigned TWO32 = 64'd1 << 32;
  localparam longint unsigned C_SAT = 64'd1 << 50;
  localparam longint unsigned Q_SAT = 64'd1 << 56;
  localparam longint          H32   = 64'sd6746518852;
  localparam longint          D32   = 64'sd74961321;
  localparam longint          P29   = 64'sd1686629713;
  localparam longint          H29   = 64'sd843314857;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_ECC    = 2'd1;
  localparam logic [1:0] REG_TOL    = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SRC  = 1;
  localparam int IDLE_SINK = 2;
  localparam int IDLE_BOTH = 3;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [31:0] wr_data;
  logic        in_taken;

  ecg_in_if  in_item ();
  ecg_out_if out_item ();

  ecef_to_geodetic_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .in_item (in_item.sink),
    .out_item(out_item.source)
  );

  longint unsigned radius_q, ecc_q, tol_q, limit_q;
  position_t       pending_pos[$];
  geodetic_t       expected_geo[$];
  int              err_count;
  int              idle_mode;

  longint step_tab[11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346,
                           64'sd534100635, 64'sd268086748, 64'sd134174063,
                           64'sd67103403, 64'sd33553749, 64'sd16777131,
                           64'sd8388597, 64'sd4194303};

  function automatic longint step_angle(int i);
    return (i <= 10) ? step_tab[i] : (64'sd1 <<< (32 - i));
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned mul_shr(longint unsigned a, longint unsigned b, int sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    return (p > SAT62) ? SAT62 : p[63:0];
  endfunction

  function automatic longint smul_shr(longint a, longint b, int sh);
    longint r;
    r = longint'(mul_shr(mag(a), mag(b), sh));
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint unsigned div_sat(longint unsigned n, int sh, longint unsigned d,
                                              longint unsigned maxq);
    longint unsigned q, r;
    if (d == 0) return maxq;
    q = n / d;
    r = n % d;
    if (q > maxq) return maxq;
    for (int k = 0; k < sh; k++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
      if (q > maxq) return maxq;
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint vector_angle(longint x, longint y, output longint len);
    longint z, t, dx, dy;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = H32;
      end else begin
        x = -y; y = t; z = -H32;
      end
    end
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += step_angle(i);
      end else begin
        x -= dx; y += dy; z -= step_angle(i);
      end
    end
    len = x;
    return z;
  endfunction

  function automatic void rotate_angle(input longint ang, output longint co,
                                       output longint si);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = ang;
    for (int i = 0; i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= step_angle(i);
      end else begin
        x += dx; y -= dy; z += step_angle(i);
      end
    end
    co = x;
    si = y;
  endfunction

  function automatic geodetic_t predict_geodetic(position_t p);
    geodetic_t       g;
    longint          x24, y24, z24, rho, lon, lat, old, co, si, num, c, alt, len, q;
    longint unsigned s2, d, root, lim;
    g = '{default: '0};
    if (p.x == 0 && p.y == 0 && p.z == 0) begin
      g.invalid = 1'b1;
      return g;
    end
    x24 = p.x * 256;
    y24 = p.y * 256;
    z24 = p.z * 256;
    rho = 0;
    c = 0;
    if (p.x == 0 && p.y == 0) begin
      lon = (p.z > 0) ? H29 : -H29;
    end else begin
      lon = (vector_angle(x24, y24, len) + 4) >>> 3;
      rho = longint'(mul_shr(len, 64'd2608131496, 32));
      if (lon >= P29) lon -= 2 * P29;
      else if (lon <= -P29) lon += 2 * P29;
    end
    lat = vector_angle(rho, z24, len);
    lim = (limit_q != 0) ? limit_q : 1;
    for (longint unsigned k = 0; k < lim; k++) begin
      old = lat;
      rotate_angle(lat, co, si);
      s2 = (mag(si) * mag(si)) >> 28;
      if (s2 > TWO32) s2 = TWO32;
      d = TWO32 - ((ecc_q * s2) >> 32);
      root = int_sqrt(d << 28);
      c = longint'(div_sat(radius_q, 38, root, C_SAT));
      num = z24 + smul_shr(longint'(mul_shr(c, ecc_q, 32)), si, 30);
      lat = vector_angle(rho, num, len);
      if (longint'(mag(lat - old)) < longint'(tol_q * 8)) break;
    end
    if (lat > H32) lat = H32;
    if (lat < -H32) lat = -H32;
    rotate_angle(lat, co, si);
    if (H32 - longint'(mag(lat)) > D32) begin
      q = (co > 0) ? longint'(div_sat(rho, 30, co, Q_SAT)) : longint'(Q_SAT);
      alt = q - c;
    end else begin
      q = longint'(div_sat(mag(z24), 30, mag(si), Q_SAT));
      if (si != 0 && ((z24 < 0) != (si < 0))) q = -q;
      else if (si == 0 && z24 < 0) q = -q;
      alt = q - longint'(mul_shr(c, TWO32 - ecc_q, 32));
    end
    alt = (alt + 128) >>> 8;
    if (alt > 64'sd4294967295) alt = 64'sd4294967295;
    if (alt < -64'sd4294967296) alt = -64'sd4294967296;
    lat = (lat + 4) >>> 3;
    if (lat > H29) lat = H29;
    if (lat < -H29) lat = -H29;
    g.latitude  = lat[30:0];
    g.longitude = lon[31:0];
    g.altitude  = alt[32:0];
    return g;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, field, got, want);
    err_count++;
  endtask

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_item.valid = 1'b0;
    in_item.pos_x = '0;
    in_item.pos_y = '0;
    in_item.pos_z = '0;
    out_item.ready = 1'b0;
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    position_t p;
    if (rst) begin
      in_item.valid <= 1'b0;
      out_item.ready <= 1'b0;
    end else begin
      if (!in_item.valid || in_taken) begin
        if (pending_pos.size() > 0 &&
            !((idle_mode == IDLE_SRC && roll(70)) || (idle_mode == IDLE_BOTH && roll(30)))) begin
          p = pending_pos.pop_front();
          in_item.valid <= 1'b1;
          in_item.pos_x <= p.x[32:0];
          in_item.pos_y <= p.y[32:0];
          in_item.pos_z <= p.z[32:0];
        end else begin
          in_item.valid <= 1'b0;
        end
      end
      out_item.ready <= !((idle_mode == IDLE_SINK && roll(70)) ||
                          (idle_mode == IDLE_BOTH && roll(30)));
    end
  end

  always @(posedge clk) begin
    position_t p;
    geodetic_t g;
    in_taken <= !rst && in_item.valid && in_item.ready;
    if (!rst) begin
      if (in_item.valid && in_item.ready) begin
        p.x = longint'(in_item.pos_x);
        p.y = longint'(in_item.pos_y);
        p.z = longint'(in_item.pos_z);
        expected_geo.push_back(predict_geodetic(p));
      end
      if (out_item.valid && out_item.ready) begin
        if (expected_geo.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          g = expected_geo.pop_front();
          if (out_item.latitude !== g.latitude)
            report_mismatch("latitude", out_item.latitude, g.latitude);
          if (out_item.longitude !== g.longitude)
            report_mismatch("longitude", out_item.longitude, g.longitude);
          if (out_item.altitude !== g.altitude)
            report_mismatch("altitude", out_item.altitude, g.altitude);
          if (out_item.invalid !== g.invalid)
            report_mismatch("invalid", out_item.invalid, g.invalid);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, longint unsigned val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val[31:0];
    case (idx)
      REG_RADIUS: radius_q = val & 64'hFFFF_FFFF;
      REG_ECC:    ecc_q = val & 64'hFFFF_FFFF;
      REG_TOL:    tol_q = val & 64'h3FF;
      default:    limit_q = val & 64'hF;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic set_config(longint unsigned a, longint unsigned e, longint unsigned t,
                            longint unsigned n);
    write_reg(REG_RADIUS, a);
    write_reg(REG_ECC, e);
    write_reg(REG_TOL, t);
    write_reg(REG_LIMIT, n);
  endtask

  task automatic push_pos(longint x, longint y, longint z);
    pending_pos.push_back('{x: x, y: y, z: z});
  endtask

  function automatic longint rand33();
    logic [32:0] v;
    v = {1'($urandom_range(0, 1)), $urandom};
    return longint'($signed(v));
  endfunction

  function automatic longint rand_span(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic longint pick_edge();
    case ($urandom_range(0, 4))
      0: return -64'sd4294967296;
      1: return 64'sd4294967295;
      2: return 0;
      3: return 1;
      default: return -1;
    endcase
  endfunction

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          push_pos(rand_span(450000000), rand_span(450000000), rand_span(450000000));
        5: push_pos(rand33(), rand33(), rand33());
        6: push_pos(0, 0, rand33());
        7: push_pos(rand_span(16), rand_span(16), rand_span(16));
        8: push_pos(pick_edge(), pick_edge(), pick_edge());
        default:
          push_pos(rand_span(3000000), rand_span(3000000), rand_span(420000000));
      endcase
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_pos.size() != 0 || in_item.valid || expected_geo.size() != 0);
  endtask

  initial begin
    err_count = 0;
    idle_mode = IDLE_NONE;
    radius_q = 417997586;
    ecc_q = 28752165;
    tol_q = 5;
    limit_q = 9;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push_pos(0, 0, 0);
    push_pos(418000000, 0, 0);
    push_pos(-418000000, 0, 0);
    push_pos(-418000000, -1, 0);
    push_pos(0, 418000000, 0);
    push_pos(0, -418000000, 0);
    push_pos(0, 0, 416600000);
    push_pos(0, 0, -416600000);
    push_pos(1, 0, 416600000);
    push_pos(64'sd4294967295, 64'sd4294967295, 64'sd4294967295);
    push_pos(-64'sd4294967296, -64'sd4294967296, -64'sd4294967296);
    push_pos(-64'sd4294967296, 64'sd4294967295, -64'sd4294967296);
    push_pos(1, 0, 0);
    push_pos(0, 0, -1);
    push_pos(-1, -1, 1);
    push_pos(295000000, 295000000, 0);
    push_pos(200000000, -150000000, 330000000);
    push_pos(-7000000, 3000000, -416000000);
    push_pos(10000, 0, -500);
    push_pos(-64'sd4294967296, 0, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:  set_config(417997586, 28752165, 5, 9);
        1:  set_config(1, 0, 0, 1);
        2:  set_config(64'd4294967295, 64'd2147483648, 1023, 15);
        3:  set_config(417997586, 28752165, 0, 0);
        4:  set_config(417997586, 64'd2147483648, 0, 15);
        5:  set_config(1, 64'd2147483648, 1023, 2);
        default:
          set_config($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(0, 32'h8000_0000),
                     $urandom_range(0, 1023), $urandom_range(0, 15));
      endcase
      idle_mode = ph % 4;
      push_random((ph == 2 || ph == 4) ? 60 : 120);
      drain();
    end

    idle_mode = IDLE_NONE;
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_geo.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #400ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ecg_pkg.sv
hw/rtl/ecg_in_if.sv
hw/rtl/ecg_out_if.sv
hw/rtl/ecg_cordic.sv
hw/rtl/ecg_mul.sv
hw/rtl/ecg_div.sv
hw/rtl/ecg_sqrt.sv
hw/rtl/ecef_to_geodetic_core.sv
tb/ecef_to_geodetic_core_tb.sv
